/* design/tsu_pkg.sv */
// Shared types, constants and helpers for the tick-sampled UART with queues.
// Used by tsu_tx, tsu_rx and tick_sampled_uart_with_fifos_top; depends on nothing.
package tsu_pkg;

    localparam int TX_DEPTH  = 16;
    localparam int RX_DEPTH  = 16;
    localparam int TX_PTR_W  = $clog2(TX_DEPTH);
    localparam int RX_PTR_W  = $clog2(RX_DEPTH);
    localparam int DATA_W    = 8;
    localparam int SLICE_W   = 8;
    localparam int CNT_W     = 4;
    localparam int FRAME_W   = DATA_W + 2;
    localparam int DATA_BITS = 8;
    localparam int BITS_W    = 4;

    // Item actions
    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_PUSH = 2'd1,
        ACT_POP  = 2'd2,
        ACT_PEEK = 2'd3
    } t_action;

    // Configuration register indexes
    typedef enum logic {
        CFG_BIT_SLICES = 1'b0,
        CFG_RX_ENABLE  = 1'b1
    } t_cfg_index;

    // Transmit side view after the item
    typedef struct packed {
        logic line;
        logic busy;
        logic accepted;
    } t_tx_status;

    // Receive side view after the item
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              valid;
        logic [CNT_W-1:0]  count;
        logic              overrun;
    } t_rx_status;

    // A bit period of zero ticks runs as one tick
    function automatic logic [SLICE_W-1:0] slices_eff(input logic [SLICE_W-1:0] s);
        return (s == '0) ? SLICE_W'(1) : s;
    endfunction

endpackage

/* design/tsu_tx.sv */
// Transmit queue (ring of TX_DEPTH bytes) and 8N1 frame shifter.
// Depends on tsu_pkg.
module tsu_tx
    import tsu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  t_action              i_action,
    input  logic [DATA_W-1:0]    i_tx_byte,
    input  logic [SLICE_W-1:0]   i_bit_slices,
    output t_tx_status           o_status
);

    logic [DATA_W-1:0]   r_queue [TX_DEPTH];
    logic [TX_PTR_W-1:0] r_head, n_head;
    logic [TX_PTR_W-1:0] r_tail, n_tail;
    logic                r_active, n_active;
    logic [FRAME_W-1:0]  r_shift, n_shift;
    logic [SLICE_W-1:0]  r_cnt, n_cnt;
    logic                r_level, n_level;

    logic [TX_PTR_W-1:0] head_next;
    logic [TX_PTR_W-1:0] tail_next;
    logic [SLICE_W-1:0]  cnt_dec;
    logic [FRAME_W-1:0]  frame;
    logic                wr_en;
    logic                accepted;

    assign head_next = (r_head == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign cnt_dec   = r_cnt - 1'b1;
    // Fresh frame: stop bit high, data LSB first, start bit low
    assign frame     = (r_shift == '0) ? {1'b1, r_queue[r_tail], 1'b0} : r_shift;

    // Advance the shifter on a tick, queue a byte on a push
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_active = r_active;
        n_shift  = r_shift;
        n_cnt    = r_cnt;
        n_level  = r_level;
        wr_en    = 1'b0;
        accepted = 1'b0;
        if (i_accept) begin
            unique case (i_action)
                ACT_TICK: begin
                    if (r_active) begin
                        if (r_cnt != '0 && cnt_dec != '0) begin
                            n_cnt = cnt_dec;
                        end else begin
                            n_cnt = '0;
                            if (r_shift == '0 && r_tail == r_head) begin
                                n_active = 1'b0;
                            end else begin
                                if (r_shift == '0) begin
                                    n_tail = tail_next;
                                end
                                n_level = frame[0];
                                n_shift = {1'b0, frame[FRAME_W-1:1]};
                                n_cnt   = slices_eff(i_bit_slices);
                            end
                        end
                    end
                end
                ACT_PUSH: begin
                    if (head_next != r_tail) begin
                        wr_en    = 1'b1;
                        n_head   = head_next;
                        n_active = 1'b1;
                        accepted = 1'b1;
                    end
                end
                ACT_POP, ACT_PEEK: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_active <= 1'b0;
            r_shift  <= '0;
            r_cnt    <= '0;
            r_level  <= 1'b1;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_active <= n_active;
            r_shift  <= n_shift;
            r_cnt    <= n_cnt;
            r_level  <= n_level;
        end
    end

    // Store pushed bytes
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_queue[r_head] <= i_tx_byte;
        end
    end

    assign o_status.line     = n_level;
    assign o_status.busy     = n_active;
    assign o_status.accepted = accepted;

endmodule

/* design/tsu_rx.sv */
// Receive sampler (start detect, mid-bit sampling) and receive queue ring.
// Depends on tsu_pkg.
module tsu_rx
    import tsu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  t_action              i_action,
    input  logic                 i_rx_line,
    input  logic [SLICE_W-1:0]   i_bit_slices,
    input  logic                 i_rx_enable,
    input  logic                 i_clear,
    output t_rx_status           o_status
);

    logic [DATA_W-1:0]   r_queue [RX_DEPTH];
    logic [RX_PTR_W-1:0] r_head, n_head;
    logic [RX_PTR_W-1:0] r_tail, n_tail;
    logic                r_active, n_active;
    logic                r_stop_wait, n_stop_wait;
    logic [DATA_W-1:0]   r_shift, n_shift;
    logic [BITS_W-1:0]   r_bits, n_bits;
    logic [SLICE_W-1:0]  r_cnt, n_cnt;

    logic [RX_PTR_W-1:0] head_next;
    logic [RX_PTR_W-1:0] tail_next;
    logic [SLICE_W-1:0]  s_eff;
    logic [SLICE_W:0]    start_dly;
    logic [SLICE_W-1:0]  cnt_dec;
    logic [BITS_W-1:0]   bits_dec;
    logic [RX_PTR_W:0]   fill;
    logic                wr_en;
    logic                overrun;
    logic                rd_valid;
    logic [DATA_W-1:0]   rd_data;

    assign head_next = (r_head == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign s_eff     = slices_eff(i_bit_slices);
    // 1.5 bit periods to the first data bit, saturated
    assign start_dly = {1'b0, s_eff} + {2'b00, s_eff[SLICE_W-1:1]};
    assign cnt_dec   = r_cnt - 1'b1;
    assign bits_dec  = r_bits - 1'b1;

    // Sample the line on a tick, read the queue on a pop or peek
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_active    = r_active;
        n_stop_wait = r_stop_wait;
        n_shift     = r_shift;
        n_bits      = r_bits;
        n_cnt       = r_cnt;
        wr_en       = 1'b0;
        overrun     = 1'b0;
        rd_valid    = 1'b0;
        rd_data     = '0;
        if (i_accept) begin
            unique case (i_action)
                ACT_TICK: begin
                    if (i_rx_enable) begin
                        if (r_stop_wait) begin
                            n_cnt = cnt_dec;
                            if (cnt_dec == '0) begin
                                n_stop_wait = 1'b0;
                                n_active    = 1'b0;
                                if (head_next == r_tail) begin
                                    overrun = 1'b1;
                                end else begin
                                    wr_en  = 1'b1;
                                    n_head = head_next;
                                end
                            end
                        end else if (!r_active) begin
                            if (!i_rx_line) begin
                                n_active = 1'b1;
                                n_shift  = '0;
                                n_cnt    = start_dly[SLICE_W] ? '1 : start_dly[SLICE_W-1:0];
                                n_bits   = BITS_W'(DATA_BITS);
                            end
                        end else begin
                            n_cnt = cnt_dec;
                            if (cnt_dec == '0) begin
                                n_cnt   = s_eff;
                                n_shift = {i_rx_line, r_shift[DATA_W-1:1]};
                                n_bits  = bits_dec;
                                if (bits_dec == '0) begin
                                    n_stop_wait = 1'b1;
                                end
                            end
                        end
                    end
                end
                ACT_PUSH: begin
                end
                ACT_POP, ACT_PEEK: begin
                    if (r_head != r_tail) begin
                        rd_valid = 1'b1;
                        rd_data  = r_queue[r_tail];
                        if (i_action == ACT_POP) begin
                            n_tail = tail_next;
                        end
                    end
                end
            endcase
        end
    end

    // Bytes waiting after the item
    always_comb begin
        fill = {1'b0, n_head} - {1'b0, n_tail};
        if (n_head < n_tail) begin
            fill = fill + (RX_PTR_W+1)'(RX_DEPTH);
        end
    end

    // Drop the queue and any frame on reset or when the receiver is switched off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_active    <= 1'b0;
            r_stop_wait <= 1'b0;
            r_shift     <= '0;
            r_bits      <= '0;
            r_cnt       <= '0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_active    <= n_active;
            r_stop_wait <= n_stop_wait;
            r_shift     <= n_shift;
            r_bits      <= n_bits;
            r_cnt       <= n_cnt;
        end
    end

    // Store received bytes
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_queue[r_head] <= r_shift;
        end
    end

    assign o_status.data    = rd_data;
    assign o_status.valid   = rd_valid;
    assign o_status.count   = CNT_W'(fill);
    assign o_status.overrun = overrun;

endmodule

/* design/tick_sampled_uart_with_fifos_top.sv */
// Tick-sampled 8N1 UART with transmit and receive queues.
// The result of an accepted item is registered and appears in the output register in the next cycle.
// Throughput: one item per cycle; the whole update of both queues, the shifter and
// the sampler is one pass of logic. A result held by output stall stalls the input.
// Reset (synchronous, active low): queues empty, line idle high, bit_slices 4,
// receiver enabled. Depends on tsu_pkg, tsu_tx and tsu_rx.
module tick_sampled_uart_with_fifos_top
    import tsu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [SLICE_W-1:0]   i_cfg_data,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_action,
    input  logic                 i_rx_line,
    input  logic [DATA_W-1:0]    i_tx_byte,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_tx_line,
    output logic                 o_tx_busy,
    output logic                 o_tx_accepted,
    output logic [DATA_W-1:0]    o_rx_data,
    output logic                 o_rx_valid,
    output logic [CNT_W-1:0]     o_rx_count,
    output logic                 o_rx_overrun
);

    logic [SLICE_W-1:0] r_bit_slices;
    logic               r_rx_enable;
    logic               r_out_valid;
    t_tx_status         r_tx_out;
    t_rx_status         r_rx_out;

    logic               accept;
    logic               rx_clear;
    t_action            action;
    t_tx_status         tx_status;
    t_rx_status         rx_status;

    // Take a new item unless a result is held back
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign action     = t_action'(i_action);
    assign rx_clear   = i_cfg_we && (t_cfg_index'(i_cfg_index) == CFG_RX_ENABLE)
                        && !i_cfg_data[0];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_slices <= SLICE_W'(4);
            r_rx_enable  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_BIT_SLICES: r_bit_slices <= i_cfg_data;
                CFG_RX_ENABLE:  r_rx_enable  <= i_cfg_data[0];
            endcase
        end
    end

    tsu_tx u_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_action     (action),
        .i_tx_byte    (i_tx_byte),
        .i_bit_slices (r_bit_slices),
        .o_status     (tx_status)
    );

    tsu_rx u_rx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_action     (action),
        .i_rx_line    (i_rx_line),
        .i_bit_slices (r_bit_slices),
        .i_rx_enable  (r_rx_enable),
        .i_clear      (rx_clear),
        .o_status     (rx_status)
    );

    // Output valid: set on an accepted item, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the result payload until the next item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tx_out <= tx_status;
            r_rx_out <= rx_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tx_line     = r_tx_out.line;
    assign o_tx_busy     = r_tx_out.busy;
    assign o_tx_accepted = r_tx_out.accepted;
    assign o_rx_data     = r_rx_out.data;
    assign o_rx_valid    = r_rx_out.valid;
    assign o_rx_count    = r_rx_out.count;
    assign o_rx_overrun  = r_rx_out.overrun;

endmodule
